@@ rtl/bpm_pkg.sv @@
// bpm_pkg: shared types and constants for the bracket pair matcher
`default_nettype none

package bpm_pkg;

  // width of a character position
  localparam int POS_W = 12;
  // largest value a position field can hold
  localparam int POS_FIELD_TOP = 4095;

  // depth of the op queue between front and back
  localparam int Q_DEPTH = 2;

  // result mark codes
  localparam logic [1:0] MARK_MATCH_OPEN  = 2'd0;
  localparam logic [1:0] MARK_MATCH_CLOSE = 2'd1;
  localparam logic [1:0] MARK_BAD         = 2'd2;

  // bracket kind, shared by opening and closing forms
  typedef enum logic [1:0] {
    KIND_BRACE  = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_SQUARE = 2'd2
  } bkind_t;

  // what the front decided about one character
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_code_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [POS_W-1:0] pos;
    op_code_t         op;
    bkind_t           kind;
    logic             line_end;
  } op_t;

  // back part sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLOSE2,
    S_FLUSH_RD,
    S_FLUSH
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/bracket_pair_matcher.sv @@
// bracket_pair_matcher: top level of the bracket pair matcher
//
// channel   handshake            payload
// input     push / full          char_code[15:0], line_end
// result    pop / empty          position[11:0], mark_kind[1:0], run_last
//
// The front classifies a character, which then waits in a two-entry queue.
// The back handles a character in S_EXEC, adds S_CLOSE2 for a pair report
// and at line end sets up the stack read in S_FLUSH_RD, then reports each
// stacked opening bracket in S_FLUSH, one stack memory read per cycle unless pop stalls.
// Reset clears the stack count, the position counter, the queue and the
// result valid flag; stack entries are written before they are read.
// full rises while the queue holds two items; a stalled pop holds the back.
`default_nettype none

module bracket_pair_matcher #(
  parameter int STACK_DEPTH = 32,
  parameter int MAX_LINE    = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [15:0]                   char_code,
  input  wire logic                          line_end,
  input  wire logic                          pop,
  output logic                               empty,
  output logic [bpm_pkg::POS_W-1:0]          position,
  output logic [1:0]                         mark_kind,
  output logic                               run_last
);
  import bpm_pkg::*;

  op_t  enq_op;
  op_t  deq_op;
  logic enq;
  logic deq;
  logic q_full;
  logic q_empty;

  assign full = q_full;

  // character classification and position
  bpm_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .line_end  (line_end),
    .q_full    (q_full),
    .enq       (enq),
    .op        (enq_op)
  );

  // decoupling queue
  bpm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_op  (enq_op),
    .q_full  (q_full),
    .deq     (deq),
    .deq_op  (deq_op),
    .q_empty (q_empty)
  );

  // stack and reporting
  bpm_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .deq_op    (deq_op),
    .q_empty   (q_empty),
    .deq       (deq),
    .pop       (pop),
    .empty     (empty),
    .position  (position),
    .mark_kind (mark_kind),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire

@@ rtl/bpm_front.sv @@
// bpm_front: classifies characters and tracks the position within the line
`default_nettype none

module bpm_front #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire logic [15:0]               char_code,
  input  wire logic                      line_end,
  input  wire logic                      q_full,
  output logic                           enq,
  output bpm_pkg::op_t                   op
);
  import bpm_pkg::*;

  localparam int PosTopInt = (MAX_LINE - 1 < POS_FIELD_TOP) ? MAX_LINE - 1 : POS_FIELD_TOP;
  localparam logic [POS_W-1:0] PosTop = POS_W'(PosTopInt);

  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_LSQR   = 16'h005B;
  localparam logic [15:0] CH_RBRACE = 16'h007D;
  localparam logic [15:0] CH_RPAREN = 16'h0029;
  localparam logic [15:0] CH_RSQR   = 16'h005D;

  logic [POS_W-1:0] char_position;
  logic [POS_W-1:0] char_position_next;

  // take an item whenever the queue has room
  assign enq = push && !q_full;

  // classify the character
  always_comb begin
    op.pos      = char_position;
    op.line_end = line_end;
    op.op       = OP_NONE;
    op.kind     = KIND_BRACE;
    case (char_code)
      CH_LBRACE: begin op.op = OP_OPEN;  op.kind = KIND_BRACE;  end
      CH_LPAREN: begin op.op = OP_OPEN;  op.kind = KIND_PAREN;  end
      CH_LSQR:   begin op.op = OP_OPEN;  op.kind = KIND_SQUARE; end
      CH_RBRACE: begin op.op = OP_CLOSE; op.kind = KIND_BRACE;  end
      CH_RPAREN: begin op.op = OP_CLOSE; op.kind = KIND_PAREN;  end
      CH_RSQR:   begin op.op = OP_CLOSE; op.kind = KIND_SQUARE; end
      default: begin
        op.op   = OP_NONE;
        op.kind = KIND_BRACE;
      end
    endcase
  end

  // saturating position counter, cleared after the line's last character
  always_comb begin
    char_position_next = char_position;
    if (enq) begin
      if (line_end) begin
        char_position_next = '0;
      end else if (char_position < PosTop) begin
        char_position_next = char_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
    end else begin
      char_position <= char_position_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bpm_queue.sv @@
// bpm_queue: short op queue between front and back
`default_nettype none

module bpm_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          enq,
  input  bpm_pkg::op_t       enq_op,
  output logic               q_full,
  input  wire logic          deq,
  output bpm_pkg::op_t       deq_op,
  output logic               q_empty
);
  import bpm_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  op_t           slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign q_full  = (fill == CW'(Q_DEPTH));
  assign q_empty = (fill == '0);
  assign deq_op  = slots[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({enq, deq})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  // queue checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(Q_DEPTH))
    else $error("queue fill out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !deq |=> fill == CW'(Q_DEPTH) || $past(enq) == 1'b0)
    else $error("queue overflow");
  a_deq_moves: assert property (@(posedge clk) disable iff (rst)
    deq && !enq && !q_empty |=> fill == $past(fill) - CW'(1))
    else $error("queue fill did not drop on dequeue");

endmodule

`default_nettype wire

@@ rtl/bpm_back.sv @@
// bpm_back: bracket stack, pair reporting and line-end flush
`default_nettype none

module bpm_back #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  bpm_pkg::op_t                    deq_op,
  input  wire logic                       q_empty,
  output logic                            deq,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [bpm_pkg::POS_W-1:0]       position,
  output logic [1:0]                      mark_kind,
  output logic                            run_last
);
  import bpm_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = POS_W + 2;

  back_state_t state;
  back_state_t state_next;

  op_t              cur;
  logic             match_r;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    count_dec;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    stack_mem [STACK_DEPTH];
  logic [EW-1:0]    rd_q;
  logic [POS_W-1:0] rd_pos;
  bkind_t           rd_kind;
  logic             out_valid;
  logic             can_emit;
  logic             stack_full;
  logic             match_now;
  logic             mem_we;
  logic             emit;
  logic [POS_W-1:0] e_pos;
  logic [1:0]       e_kind;
  logic             e_last;

  assign rd_pos     = rd_q[EW-1:2];
  assign rd_kind    = bkind_t'(rd_q[1:0]);
  assign can_emit   = !out_valid || pop;
  assign stack_full = (count == CW'(STACK_DEPTH));
  assign match_now  = (rd_kind == cur.kind);
  assign empty      = !out_valid;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!q_empty) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cur.op)
          OP_OPEN: begin
            if (!stack_full || can_emit) begin
              state_next = cur.line_end ? S_FLUSH_RD : S_IDLE;
            end
          end
          OP_CLOSE: begin
            if (can_emit) state_next = (count != '0) ? S_CLOSE2 : S_IDLE;
          end
          default: begin
            state_next = (cur.line_end && count != '0) ? S_FLUSH_RD : S_IDLE;
          end
        endcase
      end
      S_CLOSE2: begin
        if (can_emit) state_next = (cur.line_end && count != '0) ? S_FLUSH_RD : S_IDLE;
      end
      S_FLUSH_RD: state_next = S_FLUSH;
      S_FLUSH: begin
        if (can_emit && count == CW'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and stack updates per state
  always_comb begin
    deq        = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    e_pos      = cur.pos;
    e_kind     = MARK_BAD;
    e_last     = 1'b1;
    count_next = count;
    case (state)
      S_IDLE: begin
        deq = !q_empty;
      end
      S_EXEC: begin
        case (cur.op)
          OP_OPEN: begin
            if (!stack_full) begin
              mem_we     = 1'b1;
              count_next = count + CW'(1);
            end else begin
              emit   = can_emit;
              e_last = !cur.line_end;
            end
          end
          OP_CLOSE: begin
            if (count != '0) begin
              emit   = can_emit;
              e_pos  = rd_pos;
              e_kind = match_now ? MARK_MATCH_OPEN : MARK_BAD;
              e_last = 1'b0;
              if (can_emit) count_next = count - CW'(1);
            end else begin
              emit = can_emit;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      S_CLOSE2: begin
        emit   = can_emit;
        e_kind = match_r ? MARK_MATCH_CLOSE : MARK_BAD;
        e_last = !(cur.line_end && count != '0);
      end
      S_FLUSH: begin
        emit   = can_emit;
        e_pos  = rd_pos;
        e_last = (count == CW'(1));
        if (can_emit) count_next = count - CW'(1);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // read address tracks the top of the stack as it will be next cycle
  assign count_dec = count_next - CW'(1);
  assign rd_addr   = (count_next == '0) ? '0 : count_dec[AW-1:0];

  // stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[count[AW-1:0]] <= {cur.pos, cur.kind};
    end
    rd_q <= stack_mem[rd_addr];
  end

  // current item and match flag
  always_ff @(posedge clk) begin
    if (deq) begin
      cur <= deq_op;
    end
    if (state == S_EXEC) begin
      match_r <= match_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      position  <= e_pos;
      mark_kind <= e_kind;
      run_last  <= e_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stack and sequencer checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count out of range");
  a_flush_ends_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH && can_emit && count == CW'(1) |=> count == '0 && state == S_IDLE)
    else $error("flush did not empty the stack");
  a_close2_from_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_CLOSE2 |-> $past(state) == S_EXEC || $past(state) == S_CLOSE2)
    else $error("second pair result without a pop");
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> count != '0)
    else $error("flush on an empty stack");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// testbench: self-checking bench for the bracket pair matcher, directed table then random lines
`default_nettype none

module testbench;
  import bpm_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int MAX_LINE    = 4096;
  localparam int POS_TOP     = (MAX_LINE - 1 < POS_FIELD_TOP) ? MAX_LINE - 1 : POS_FIELD_TOP;
  localparam int TAIL_CYCLES = 64;
  localparam int RAND_ITEMS  = 450;

  // bracket character codes
  localparam logic [15:0] CH_LBRACE = 16'h007B;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_RBRACE = 16'h007D;
  localparam logic [15:0] CH_RPAREN = 16'h0029;
  localparam logic [15:0] CH_RBRACK = 16'h005D;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [1:0]       kind;
    logic             last;
  } mark_t;

  // one row of the directed table; typed rows carry their marks
  typedef struct packed {
    logic [15:0]      ch;
    logic             le;
    logic             typed;
    logic [1:0]       n;
    logic [POS_W-1:0] p0;
    logic [1:0]       k0;
    logic [POS_W-1:0] p1;
    logic [1:0]       k1;
  } row_t;

  localparam int N_ROWS = 23;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{CH_RPAREN, 1'b0, 1'b1, 2'd1, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{16'hFFFF,  1'b0, 1'b1, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{16'h0000,  1'b0, 1'b1, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACE, 1'b0, 1'b1, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RBRACE, 1'b0, 1'b1, 2'd2, 12'd3, MARK_MATCH_OPEN, 12'd4, MARK_MATCH_CLOSE},
    '{CH_LPAREN, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACE, 1'b1, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LPAREN, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RPAREN, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RBRACE, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RPAREN, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{16'h017B,  1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_RBRACK, 1'b1, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{16'hFFFF,  1'b1, 1'b1, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACE, 1'b1, 1'b1, 2'd1, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LPAREN, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{CH_LBRACK, 1'b0, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD},
    '{16'h8000,  1'b1, 1'b0, 2'd0, 12'd0, MARK_BAD, 12'd0, MARK_BAD}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [15:0]      char_code = 16'h0000;
  logic             line_end = 1'b0;
  logic             pop = 1'b0;
  logic             empty;
  logic [POS_W-1:0] position;
  logic [1:0]       mark_kind;
  logic             run_last;

  // predictor state
  logic [13:0]      open_stack_copy [STACK_DEPTH];
  int               stack_fill = 0;
  logic [POS_W-1:0] next_pos = '0;
  int               deepest = 0;

  mark_t       pending_marks [$];
  logic [15:0] line_buf [$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          items_sent = 0;
  int          lines_sent = 0;
  int          marks_checked = 0;
  int          mark_errors = 0;

  bracket_pair_matcher #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .char_code(char_code),
    .line_end (line_end),
    .pop      (pop),
    .empty    (empty),
    .position (position),
    .mark_kind(mark_kind),
    .run_last (run_last)
  );

  // clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    #3200000;
    $display("bracket_pair_matcher test failed");
    $finish;
  end

  function automatic logic is_opening(input logic [15:0] ch, output bkind_t k);
    is_opening = 1'b1;
    k = KIND_BRACE;
    case (ch)
      CH_LBRACE: k = KIND_BRACE;
      CH_LPAREN: k = KIND_PAREN;
      CH_LBRACK: k = KIND_SQUARE;
      default: is_opening = 1'b0;
    endcase
  endfunction

  function automatic logic is_closing(input logic [15:0] ch, output bkind_t k);
    is_closing = 1'b1;
    k = KIND_BRACE;
    case (ch)
      CH_RBRACE: k = KIND_BRACE;
      CH_RPAREN: k = KIND_PAREN;
      CH_RBRACK: k = KIND_SQUARE;
      default: is_closing = 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] bracket_char(input bkind_t k, input logic closing);
    case (k)
      KIND_BRACE:  bracket_char = closing ? CH_RBRACE : CH_LBRACE;
      KIND_PAREN:  bracket_char = closing ? CH_RPAREN : CH_LPAREN;
      default:     bracket_char = closing ? CH_RBRACK : CH_LBRACK;
    endcase
  endfunction

  // any 16-bit code that is not a bracket
  function automatic logic [15:0] plain_char();
    logic [15:0] c;
    bkind_t k;
    c = 16'($urandom_range(65535));
    while (is_opening(c, k) || is_closing(c, k))
      c = 16'($urandom_range(65535));
    return c;
  endfunction

  function automatic bkind_t rand_kind();
    return bkind_t'($urandom_range(2));
  endfunction

  // bracket matching prediction for one accepted item
  task automatic predict_marks(input logic [15:0] ch, input logic le, input logic keep);
    mark_t  step [$];
    bkind_t k;
    logic [13:0] e;
    logic [POS_W-1:0] pos;
    pos = next_pos;
    if (is_opening(ch, k)) begin
      if (stack_fill < STACK_DEPTH) begin
        open_stack_copy[stack_fill] = {pos, k};
        stack_fill++;
        if (stack_fill > deepest) deepest = stack_fill;
      end else begin
        step.push_back('{pos, MARK_BAD, 1'b0});
      end
    end else if (is_closing(ch, k)) begin
      if (stack_fill > 0) begin
        stack_fill--;
        e = open_stack_copy[stack_fill];
        if (e[1:0] == k) begin
          step.push_back('{e[13:2], MARK_MATCH_OPEN, 1'b0});
          step.push_back('{pos, MARK_MATCH_CLOSE, 1'b0});
        end else begin
          step.push_back('{e[13:2], MARK_BAD, 1'b0});
          step.push_back('{pos, MARK_BAD, 1'b0});
        end
      end else begin
        step.push_back('{pos, MARK_BAD, 1'b0});
      end
    end
    if (next_pos < POS_W'(POS_TOP)) next_pos++;
    // line end flushes the stack from the top down
    if (le) begin
      while (stack_fill > 0) begin
        stack_fill--;
        step.push_back('{open_stack_copy[stack_fill][13:2], MARK_BAD, 1'b0});
      end
      next_pos = '0;
    end
    if (step.size() > 0) step[step.size()-1].last = 1'b1;
    if (keep)
      foreach (step[i]) pending_marks.push_back(step[i]);
  endtask

  // offer one item and wait until it is taken
  task automatic offer_char(input logic [15:0] ch, input logic le);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    char_code <= ch;
    line_end  <= le;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic feed_char(input logic [15:0] ch, input logic le);
    offer_char(ch, le);
    predict_marks(ch, le, 1'b1);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) feed_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  // hold the sender until every expected mark is out
  task automatic drain_marks();
    @(negedge clk);
    push <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // mostly balanced nesting with plain text, some wrong closers and dangling openers
  task automatic build_nested(input int depth_cap);
    bkind_t open_k [$];
    bkind_t k;
    int len;
    int r;
    line_buf.delete();
    len = $urandom_range(40, 1);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 35 && open_k.size() < depth_cap) begin
        k = rand_kind();
        open_k.push_back(k);
        line_buf.push_back(bracket_char(k, 1'b0));
      end else if (r < 65 && open_k.size() > 0) begin
        k = open_k.pop_back();
        if ($urandom_range(99) < 8) k = bkind_t'((int'(k) + 1) % 3);
        line_buf.push_back(bracket_char(k, 1'b1));
      end else begin
        line_buf.push_back(plain_char());
      end
    end
    if ($urandom_range(99) < 80)
      while (open_k.size() > 0) line_buf.push_back(bracket_char(open_k.pop_back(), 1'b1));
  endtask

  // random brackets and raw codes with no structure
  task automatic build_noise();
    int len;
    line_buf.delete();
    len = $urandom_range(20, 1);
    repeat (len) begin
      if ($urandom_range(1)) line_buf.push_back(bracket_char(rand_kind(), 1'($urandom_range(1))));
      else line_buf.push_back(16'($urandom_range(65535)));
    end
  endtask

  // openers around the stack depth, often enough to fill the stack and overflow it
  task automatic build_deep();
    int n;
    line_buf.delete();
    n = $urandom_range(STACK_DEPTH + 4, STACK_DEPTH - 2);
    repeat (n) begin
      line_buf.push_back(bracket_char(rand_kind(), 1'b0));
      if ($urandom_range(99) < 10) line_buf.push_back(plain_char());
    end
    repeat ($urandom_range(6)) line_buf.push_back(bracket_char(rand_kind(), 1'b1));
  endtask

  // receiver side: random pop
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  // compare each taken mark with the oldest expectation
  always @(posedge clk) begin : check_marks
    mark_t want;
    if (!rst && pop && !empty) begin
      if (pending_marks.size() == 0) begin
        mark_errors++;
        if (mark_errors <= 10)
          $display("unexpected mark: pos=%0d kind=%0d last=%0d",
                   position, mark_kind, run_last);
      end else begin
        want = pending_marks.pop_front();
        marks_checked++;
        if (position !== want.pos || mark_kind !== want.kind || run_last !== want.last) begin
          mark_errors++;
          if (mark_errors <= 10)
            $display("mark mismatch: expected pos=%0d kind=%0d last=%0d, got pos=%0d kind=%0d last=%0d",
                     want.pos, want.kind, want.last, position, mark_kind, run_last);
        end
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    row_t row;
    int r;
    send_idle = 34;
    recv_idle = 72;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      offer_char(row.ch, row.le);
      predict_marks(row.ch, row.le, !row.typed);
      if (row.typed) begin
        if (row.n >= 2'd1) pending_marks.push_back('{row.p0, row.k0, row.n == 2'd1});
        if (row.n == 2'd2) pending_marks.push_back('{row.p1, row.k1, 1'b1});
      end
    end

    // random lines in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 72 : 0;
      recv_idle = (ph == 0) ? 72 : (ph == 1) ? 34 : 0;
      drain_marks();
      while (items_sent < N_ROWS + (ph + 1) * RAND_ITEMS / 3) begin
        r = $urandom_range(99);
        if (r < 70) build_nested($urandom_range(8, 1));
        else if (r < 88) build_noise();
        else build_deep();
        send_line();
      end
    end

    // wind down
    @(negedge clk);
    push <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d characters in %0d lines, checked %0d marks, stack reached depth %0d",
             items_sent, lines_sent, marks_checked, deepest);
    if (mark_errors == 0 && pending_marks.size() == 0) begin
      $display("bracket_pair_matcher test passed");
    end else begin
      $display("%0d mismatches, %0d marks still expected", mark_errors, pending_marks.size());
      $display("bracket_pair_matcher test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
